FILE: rtl/core/s256_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
package s256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] block_t;

  // Function codes carried in the input tuser bit.
  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam hash_t HASH_INIT = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Round constant table.
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t ror32(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

FILE: rtl/core/s256_front.sv
// Input queue: accepts items and holds them until the back end takes them.
module s256_front import s256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_byte,
  output logic       q_valid,
  input  logic       q_pop,
  output logic       q_func,
  output logic [7:0] q_byte
);

  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [8:0] mem_r [2];
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_func   = mem_r[rd_ptr_r][8];
  assign q_byte   = mem_r[rd_ptr_r][7:0];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= {in_func, in_byte};
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

FILE: rtl/core/s256_round.sv
// Compression engine: one round per cycle with a rolling message schedule.
module s256_round import s256_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  block_t blk,
  input  hash_t  hash_in,
  output logic   done,
  output hash_t  hash_out
);

  logic   busy_r;
  logic   fin_r;
  logic [5:0] rnd_r;
  hash_t  s_r;
  block_t w_r;
  word_t  big1, big0, ch, maj, t1, t2, sig0, sig1, w_new;

  // Round function on the working variables.
  always_comb begin
    big1  = ror32(s_r[4], 6) ^ ror32(s_r[4], 11) ^ ror32(s_r[4], 25);
    ch    = (s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6]);
    t1    = s_r[7] + big1 + ch + round_k(rnd_r) + w_r[0];
    big0  = ror32(s_r[0], 2) ^ ror32(s_r[0], 13) ^ ror32(s_r[0], 22);
    maj   = (s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]);
    t2    = big0 + maj;
    sig0  = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
    sig1  = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + sig0 + w_r[9] + sig1;
  end

  // Final feed-forward add.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_out[i] = hash_in[i] + s_r[i];
    end
  end

  assign done = fin_r;

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= 6'd0;
    end else begin
      fin_r <= busy_r && (rnd_r == 6'd63);
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 6'd0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) busy_r <= 1'b0;
      end
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (start) begin
      s_r <= hash_in;
      w_r <= blk;
    end else if (busy_r) begin
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule

FILE: rtl/core/s256_back.sv
// Back end: block assembly, padding, compression control and digest output.
module s256_back import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  logic        q_func,
  input  logic [7:0]  q_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  hash_t       hash_r;
  block_t      blk_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [63:0] len_r;
  logic        pad_first_r;
  logic        len_phase_r;
  logic        pad_mode_r;
  logic        ret_out_r, ret_out_nxt;
  logic        start_r;
  logic [2:0]  idx_r;
  logic        push;
  logic [7:0]  push_byte;
  logic        len_push;
  logic        done;
  hash_t       hash_sum;

  s256_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .blk     (blk_r),
    .hash_in (hash_r),
    .done    (done),
    .hash_out(hash_sum)
  );

  // Byte source for the block buffer.
  always_comb begin
    push      = 1'b0;
    push_byte = q_byte;
    len_push  = 1'b0;
    q_pop     = 1'b0;
    if (state_r == ST_IDLE) begin
      q_pop = q_valid;
      push  = q_valid && (q_func == FUNC_ABSORB);
    end else if (state_r == ST_PAD) begin
      push = 1'b1;
      priority if (pad_first_r) begin
        push_byte = PAD_BYTE;
      end else if (len_phase_r || fill_r == LEN_OFFSET) begin
        push_byte = len_r[63:56];
        len_push  = 1'b1;
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    ret_out_nxt = ret_out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_func == FUNC_FINISH) begin
          state_nxt = ST_PAD;
        end else if (push && fill_r == 6'd63) begin
          state_nxt   = ST_COMP;
          ret_out_nxt = 1'b0;
        end
      end
      ST_PAD: begin
        if (fill_r == 6'd63) begin
          state_nxt   = ST_COMP;
          ret_out_nxt = len_push;
        end
      end
      ST_COMP: begin
        // A length block goes to output; other padding continues; data returns to idle.
        if (done) state_nxt = ret_out_r ? ST_OUT : (pad_mode_r ? ST_PAD : ST_IDLE);
      end
      default: begin
        if (out_ready && idx_r == 3'd7) state_nxt = ST_IDLE;
      end
    endcase
  end

  // Block buffer: big-endian byte lanes.
  always_ff @(posedge clk) begin
    if (push) begin
      unique case (fill_r[1:0])
        2'd0: blk_r[fill_r[5:2]][31:24] <= push_byte;
        2'd1: blk_r[fill_r[5:2]][23:16] <= push_byte;
        2'd2: blk_r[fill_r[5:2]][15:8]  <= push_byte;
        default: blk_r[fill_r[5:2]][7:0] <= push_byte;
      endcase
    end
  end

  // Length register shifts out one byte per length push.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid && q_func == FUNC_FINISH) begin
      len_r <= bits_r;
    end else if (len_push) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

  // Control and hash state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= HASH_INIT;
      fill_r      <= 6'd0;
      bits_r      <= 64'd0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
      pad_mode_r  <= 1'b0;
      ret_out_r   <= 1'b0;
      start_r     <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      ret_out_r <= ret_out_nxt;
      start_r   <= push && fill_r == 6'd63;
      if (push) fill_r <= fill_r + 6'd1;
      if (state_r == ST_IDLE && push) bits_r <= bits_r + 64'd8;
      if (state_r == ST_IDLE && q_valid && q_func == FUNC_FINISH) begin
        pad_first_r <= 1'b1;
        len_phase_r <= 1'b0;
        pad_mode_r  <= 1'b1;
      end else if (state_r == ST_PAD) begin
        pad_first_r <= 1'b0;
        if (len_push) len_phase_r <= 1'b1;
      end else if (state_r == ST_COMP && done && !ret_out_r) begin
        pad_first_r <= 1'b0;
      end
      if (done) hash_r <= hash_sum;
      if (state_r == ST_OUT && out_ready) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          hash_r      <= HASH_INIT;
          fill_r      <= 6'd0;
          bits_r      <= 64'd0;
          len_phase_r <= 1'b0;
          pad_mode_r  <= 1'b0;
        end
      end
    end
  end

  // Digest words come straight from the held hash state.
  assign out_valid = (state_r == ST_OUT);
  assign out_word  = hash_r[idx_r];
  assign out_index = idx_r;
  assign out_last  = (idx_r == 3'd7);

endmodule

FILE: rtl/core/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher.
//
//  channel  | direction | tdata                              | tuser / tlast
//  in_      | slave     | [7:0] data_byte                    | tuser: func
//  out_     | master    | [31:0] digest_word, [34:32] index  | tlast: last_word
//
// An absorb item is taken from the queue while the back end is idle; every 64th byte
// starts a compression that runs one round per cycle, during which input waits in a
// two-entry queue. A finish item pads one byte per cycle and runs one or two
// compressions, then emits eight words, one per cycle while out_tready is high.
// Reset loads the initial hash values and clears all counts; the block buffer
// needs no clearing.
module sha256_byte_stream_hasher_unit import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        out_tlast   // last_word
);

  logic        q_valid;
  logic        q_pop;
  logic        q_func;
  logic [7:0]  q_byte;
  logic [31:0] word;
  logic [2:0]  index;

  s256_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_func (in_tuser),
    .in_byte (in_tdata),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_func  (q_func),
    .q_byte  (q_byte)
  );

  s256_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_func   (q_func),
    .q_byte   (q_byte),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_word (word),
    .out_index(index),
    .out_last (out_tlast)
  );

  // Pack the result item.
  assign out_tdata = {5'd0, index, word};

endmodule

FILE: verif/sha256_digest_checker.sv
// Checker that predicts SHA-256 digests from the input items and compares output items.
`timescale 1ns / 100ps

module sha256_digest_checker import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  localparam word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  word_t        chain [8];
  logic [7:0]   msg_block [64];
  logic [5:0]   byte_count;
  logic [63:0]  bit_length;
  digest_item_t digest_queue [$];

  function automatic word_t rotr(word_t v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One 64-round compression of the buffered block into the chaining value.
  task automatic compress_chain();
    word_t sched [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      sched[i] = sched[i-16] + sched[i-7]
               + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[i] + sched[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic append_byte(logic [7:0] b);
    msg_block[byte_count] = b;
    byte_count++;
    if (byte_count == 6'd0) compress_chain();
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = HASH_INIT[i];
    byte_count = '0;
    bit_length = '0;
  endtask

  // Padding, length and digest words for a finish item.
  task automatic finish_message();
    logic [63:0] total;
    total = bit_length;
    append_byte(PAD_BYTE);
    while (byte_count != LEN_OFFSET) append_byte(8'h00);
    for (int i = 0; i < 8; i++) append_byte(total[63-8*i -: 8]);
    for (int i = 0; i < 8; i++)
      digest_queue.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
    restart_message();
  endtask

  initial begin
    fail_count = 0;
    restart_message();
  end

  assign pending_words = digest_queue.size();

  always @(posedge clk) begin
    digest_item_t want;
    if (rst_n) begin
      // Input side: absorb or finish.
      if (in_tvalid && in_tready) begin
        if (in_tuser == FUNC_FINISH) begin
          finish_message();
        end else begin
          append_byte(in_tdata);
          bit_length += 64'd8;
        end
      end
      // Output side: compare with the oldest expected word.
      if (out_tvalid && out_tready) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected item tdata=%h tlast=%b", $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = digest_queue.pop_front();
          if (out_tdata[31:0] !== want.word || out_tdata[34:32] !== want.index ||
              out_tdata[39:35] !== 5'd0 || out_tlast !== want.last) begin
            $display("%0t: mismatch expected word=%h index=%0d last=%b, got word=%h index=%0d last=%b pad=%h",
                     $time, want.word, want.index, want.last, out_tdata[31:0],
                     out_tdata[34:32], out_tlast, out_tdata[39:35]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: verif/sha256_byte_stream_hasher_unit_tb.sv
// Testbench top: byte stimulus, output back-pressure and the final verdict.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_unit_tb import s256_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = FUNC_ABSORB;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  bit          calm_input = 1'b0;
  bit          calm_output = 1'b0;
  bit          hold_output = 1'b0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher_unit dut (.*);

  sha256_digest_checker checker_i (.*);

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, none while calm, ready held low while held.
  always @(negedge clk) begin
    if (hold_output) out_tready <= 1'b0;
    else out_tready <= calm_output || ($urandom_range(99) >= 18);
  end

  // Offer one item and wait until it is accepted; valid stays up for the next item.
  task automatic send_item(logic func, logic [7:0] b);
    while (!calm_input && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, int mode);
    for (int i = 0; i < len; i++)
      case (mode)
        0: send_item(FUNC_ABSORB, 8'h00);
        1: send_item(FUNC_ABSORB, 8'hff);
        default: send_item(FUNC_ABSORB, 8'($urandom_range(255)));
      endcase
    send_item(FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message and single extreme bytes.
    send_message(0, 2);
    send_message(1, 0);
    send_message(1, 1);

    // Long receiver hold while a two-block message keeps arriving, then a
    // calm stretch. The second block holds 56 bytes, so padding spills over.
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
        calm_input = 1'b1;
        calm_output = 1'b1;
      end
      send_message(120, 2);
    join
    calm_input = 1'b0;
    calm_output = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
